>>> sv/rlpd_pkg.sv
// Shared constants, types and the local maximum test for the raster peak detector.
package rlpd_pkg;

    localparam int MAX_COLS    = 1024;
    localparam int MAX_ROWS    = 1024;
    localparam int PIXEL_BITS  = 16;

    localparam int COL_BITS    = $clog2(MAX_COLS);
    localparam int ROW_BITS    = $clog2(MAX_ROWS);
    localparam int DIM_BITS    = 11;
    localparam int COUNT_BITS  = 21;
    localparam int CFG_BITS    = 11;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCOUNT_BITS = $clog2(QUEUE_DEPTH + 1);

    localparam logic REG_GRID_ROWS = 1'b0;
    localparam logic REG_GRID_COLS = 1'b1;

    // Result slots of one request, in the order they are delivered.
    localparam logic [1:0] SLOT_UP_LEFT = 2'd0;
    localparam logic [1:0] SLOT_UP      = 2'd1;
    localparam logic [1:0] SLOT_LEFT    = 2'd2;
    localparam logic [1:0] SLOT_HERE    = 2'd3;

    typedef logic [PIXEL_BITS-1:0] pixel_t;

    typedef struct packed {
        logic [ROW_BITS-1:0] row;
        logic [COL_BITS-1:0] col;
        logic [3:0]          mask;
        logic [3:0]          peak;
        logic                frame_end;
    } decision_t;

    function automatic logic is_local_max(pixel_t centre, pixel_t nb [8], logic [7:0] used);
        logic ok;
        ok = 1'b1;
        for (int k = 0; k < 8; k++) begin
            if (used[k] && (nb[k] >= centre))
            begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

endpackage

>>> sv/rlpd_if.sv
// Handshake channels for the pixel requests and the decision results.
interface rlpd_pixel_if import rlpd_pkg::*; ();
    logic   valid;
    logic   ready;
    pixel_t pixel_value;

    modport source (output valid, output pixel_value, input ready);
    modport sink (input valid, input pixel_value, output ready);
endinterface

interface rlpd_result_if import rlpd_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [DIM_BITS-1:0]   pixel_row;
    logic [DIM_BITS-1:0]   pixel_col;
    logic                  is_peak;
    logic [COUNT_BITS-1:0] peak_total;
    logic                  run_end;

    modport source (output valid, output pixel_row, output pixel_col, output is_peak,
                    output peak_total, output run_end, input ready);
    modport sink (input valid, input pixel_row, input pixel_col, input is_peak,
                  input peak_total, input run_end, output ready);
endinterface

>>> sv/raster_local_peak_detector_3x3.sv
// Top level of the raster 3x3 local peak detector.
// Path: hold register, queue, output register. Throughput: one pixel per cycle while the
// queue has room; results leave at one per cycle from the back end while ready, which
// sets the rate when a pixel decides up to four results at the right edge and last row.
// Reset: grid size 1 x 1, raster position, queue and peak count cleared, output empty.
// The line memory is not cleared; entries read before they are written are never used.
module raster_local_peak_detector_3x3 import rlpd_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [CFG_BITS-1:0] cfg_data,
    rlpd_pixel_if.sink          pixels,
    rlpd_result_if.source       results
);

    logic      push;
    decision_t push_data;
    logic      q_full;
    logic      pop;
    decision_t head;
    logic      empty;

    rlpd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pixels    (pixels),
        .push      (push),
        .push_data (push_data),
        .q_full    (q_full)
    );

    rlpd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .head      (head),
        .empty     (empty)
    );

    rlpd_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .restart (cfg_we),
        .head    (head),
        .empty   (empty),
        .pop     (pop),
        .results (results)
    );

endmodule

>>> sv/rlpd_front.sv
// Front end: grid registers, raster position, line memory, 3x3 window and peak decisions.
module rlpd_front import rlpd_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [CFG_BITS-1:0] cfg_data,
    rlpd_pixel_if.sink          pixels,
    output logic                push,
    output decision_t           push_data,
    input  logic                q_full
);

    logic [DIM_BITS-1:0]     rows_reg;
    logic [DIM_BITS-1:0]     cols_reg;
    logic [ROW_BITS-1:0]     row_reg;
    logic [ROW_BITS-1:0]     row_next;
    logic [COL_BITS-1:0]     col_reg;
    logic [COL_BITS-1:0]     col_next;
    logic                    hold_valid_reg;
    pixel_t                  hold_pix_reg;
    logic [ROW_BITS-1:0]     hold_row_reg;
    logic [COL_BITS-1:0]     hold_col_reg;
    logic [2*PIXEL_BITS-1:0] rd_reg;
    logic [2*PIXEL_BITS-1:0] wr_data;
    logic [2*PIXEL_BITS-1:0] line_mem [MAX_COLS];
    pixel_t                  win_reg [3][3];
    pixel_t                  win_next [3][3];
    logic                    accept;
    logic                    leave;
    logic                    bypass;
    logic                    last_col;
    logic                    last_row;
    logic                    r1;
    logic                    r2;
    logic                    c1;
    logic                    c2;
    logic [DIM_BITS-1:0]     clamped_rows;
    logic [DIM_BITS-1:0]     clamped_cols;
    pixel_t                  nb [4][8];
    logic [7:0]              used [4];
    decision_t               dec;

    // Out-of-range sizes are pulled into 1 .. maximum when written.
    always_comb
    begin
        clamped_rows = DIM_BITS'(cfg_data);
        clamped_cols = DIM_BITS'(cfg_data);
        if (cfg_data == '0)
        begin
            clamped_rows = DIM_BITS'(1);
            clamped_cols = DIM_BITS'(1);
        end
        else
        begin
            if (cfg_data > CFG_BITS'(MAX_ROWS))
            begin
                clamped_rows = DIM_BITS'(MAX_ROWS);
            end
            if (cfg_data > CFG_BITS'(MAX_COLS))
            begin
                clamped_cols = DIM_BITS'(MAX_COLS);
            end
        end
    end

    always_comb
    begin
        col_next = col_reg + 1'b1;
        row_next = row_reg;
        if ((DIM_BITS'(col_reg) + 1'b1) == cols_reg)
        begin
            col_next = '0;
            row_next = row_reg + 1'b1;
            if ((DIM_BITS'(row_reg) + 1'b1) == rows_reg)
            begin
                row_next = '0;
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            win_next[i][0] = win_reg[i][1];
            win_next[i][1] = win_reg[i][2];
        end
        win_next[0][2] = rd_reg[2*PIXEL_BITS-1:PIXEL_BITS];
        win_next[1][2] = rd_reg[PIXEL_BITS-1:0];
        win_next[2][2] = hold_pix_reg;
    end

    assign wr_data  = {rd_reg[PIXEL_BITS-1:0], hold_pix_reg};
    assign last_col = (DIM_BITS'(hold_col_reg) == (cols_reg - 1'b1));
    assign last_row = (DIM_BITS'(hold_row_reg) == (rows_reg - 1'b1));
    assign r1       = (hold_row_reg != '0);
    assign r2       = (hold_row_reg > ROW_BITS'(1));
    assign c1       = (hold_col_reg != '0);
    assign c2       = (hold_col_reg > COL_BITS'(1));

    // Neighbours of the four candidate centres; a neighbour counts only inside the grid.
    always_comb
    begin
        for (int s = 0; s < 4; s++)
        begin
            used[s] = '0;
            for (int k = 0; k < 8; k++)
            begin
                nb[s][k] = '0;
            end
        end

        nb[SLOT_UP_LEFT][0] = win_next[0][0];  used[SLOT_UP_LEFT][0] = r2 & c2;
        nb[SLOT_UP_LEFT][1] = win_next[0][1];  used[SLOT_UP_LEFT][1] = r2;
        nb[SLOT_UP_LEFT][2] = win_next[0][2];  used[SLOT_UP_LEFT][2] = r2;
        nb[SLOT_UP_LEFT][3] = win_next[1][0];  used[SLOT_UP_LEFT][3] = c2;
        nb[SLOT_UP_LEFT][4] = win_next[1][2];  used[SLOT_UP_LEFT][4] = 1'b1;
        nb[SLOT_UP_LEFT][5] = win_next[2][0];  used[SLOT_UP_LEFT][5] = c2;
        nb[SLOT_UP_LEFT][6] = win_next[2][1];  used[SLOT_UP_LEFT][6] = 1'b1;
        nb[SLOT_UP_LEFT][7] = win_next[2][2];  used[SLOT_UP_LEFT][7] = 1'b1;

        nb[SLOT_UP][0] = win_next[0][1];  used[SLOT_UP][0] = r2 & c1;
        nb[SLOT_UP][1] = win_next[0][2];  used[SLOT_UP][1] = r2;
        nb[SLOT_UP][2] = win_next[1][1];  used[SLOT_UP][2] = c1;
        nb[SLOT_UP][3] = win_next[2][1];  used[SLOT_UP][3] = c1;
        nb[SLOT_UP][4] = win_next[2][2];  used[SLOT_UP][4] = 1'b1;

        nb[SLOT_LEFT][0] = win_next[1][0];  used[SLOT_LEFT][0] = r1 & c2;
        nb[SLOT_LEFT][1] = win_next[1][1];  used[SLOT_LEFT][1] = r1;
        nb[SLOT_LEFT][2] = win_next[1][2];  used[SLOT_LEFT][2] = r1;
        nb[SLOT_LEFT][3] = win_next[2][0];  used[SLOT_LEFT][3] = c2;
        nb[SLOT_LEFT][4] = win_next[2][2];  used[SLOT_LEFT][4] = 1'b1;

        nb[SLOT_HERE][0] = win_next[1][1];  used[SLOT_HERE][0] = r1 & c1;
        nb[SLOT_HERE][1] = win_next[1][2];  used[SLOT_HERE][1] = r1;
        nb[SLOT_HERE][2] = win_next[2][1];  used[SLOT_HERE][2] = c1;
    end

    always_comb
    begin
        dec.row                 = hold_row_reg;
        dec.col                 = hold_col_reg;
        dec.mask[SLOT_UP_LEFT]  = r1 & c1;
        dec.mask[SLOT_UP]       = r1 & last_col;
        dec.mask[SLOT_LEFT]     = last_row & c1;
        dec.mask[SLOT_HERE]     = last_row & last_col;
        dec.peak[SLOT_UP_LEFT]  = is_local_max(win_next[1][1], nb[SLOT_UP_LEFT], used[SLOT_UP_LEFT]);
        dec.peak[SLOT_UP]       = is_local_max(win_next[1][2], nb[SLOT_UP], used[SLOT_UP]);
        dec.peak[SLOT_LEFT]     = is_local_max(win_next[2][1], nb[SLOT_LEFT], used[SLOT_LEFT]);
        dec.peak[SLOT_HERE]     = is_local_max(win_next[2][2], nb[SLOT_HERE], used[SLOT_HERE]);
        dec.frame_end           = last_row & last_col;
    end

    assign leave        = hold_valid_reg && ((dec.mask == '0) || !q_full);
    assign pixels.ready = !hold_valid_reg || leave;
    assign accept       = pixels.valid && pixels.ready;
    assign bypass       = hold_valid_reg && (hold_col_reg == col_reg);
    assign push         = leave && (dec.mask != '0);
    assign push_data    = dec;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg       <= DIM_BITS'(1);
            cols_reg       <= DIM_BITS'(1);
            row_reg        <= '0;
            col_reg        <= '0;
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_GRID_ROWS)
                begin
                    rows_reg <= clamped_rows;
                end
                else
                begin
                    cols_reg <= clamped_cols;
                end
                row_reg <= '0;
                col_reg <= '0;
            end
            else if (accept)
            begin
                row_reg <= row_next;
                col_reg <= col_next;
            end
            if (accept)
            begin
                hold_valid_reg <= 1'b1;
            end
            else if (leave)
            begin
                hold_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hold_pix_reg <= pixels.pixel_value;
            hold_row_reg <= row_reg;
            hold_col_reg <= col_reg;
        end
        if (leave)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    win_reg[i][j] <= win_next[i][j];
                end
            end
        end
    end

    // Line memory: one entry holds the upper and middle rows of a column.
    always_ff @(posedge clk)
    begin
        if (leave)
        begin
            line_mem[hold_col_reg] <= wr_data;
        end
        if (accept)
        begin
            rd_reg <= bypass ? wr_data : line_mem[col_reg];
        end
    end

    a_col_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
        DIM_BITS'(col_reg) < cols_reg)
        else $error("column position beyond the grid");

    a_row_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
        DIM_BITS'(row_reg) < rows_reg)
        else $error("row position beyond the grid");

    a_accept_holds: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> hold_valid_reg)
        else $error("accepted request not held");

endmodule

>>> sv/rlpd_queue.sv
// Short queue of decided requests between the front and back ends.
module rlpd_queue import rlpd_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  decision_t push_data,
    output logic      full,
    input  logic      pop,
    output decision_t head,
    output logic      empty
);

    decision_t              slots_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]   wr_ptr_reg;
    logic [QPTR_BITS-1:0]   rd_ptr_reg;
    logic [QCOUNT_BITS-1:0] count_reg;
    logic [QCOUNT_BITS-1:0] count_next;

    assign full  = (count_reg == QCOUNT_BITS'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = slots_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("pop from an empty queue");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCOUNT_BITS'(QUEUE_DEPTH))
        else $error("queue count out of range");

endmodule

>>> sv/rlpd_back.sv
// Back end: splits each queued request into results, keeps the peak count, drives the output.
module rlpd_back import rlpd_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       restart,
    input  decision_t  head,
    input  logic       empty,
    output logic       pop,
    rlpd_result_if.source results
);

    logic [3:0]            done_mask_reg;
    logic [3:0]            done_mask_next;
    logic [3:0]            pending;
    logic [1:0]            sel;
    logic                  last;
    logic                  load;
    logic                  peak;
    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;
    logic [COUNT_BITS-1:0] total;
    logic                  out_valid_reg;
    logic [DIM_BITS-1:0]   out_row_reg;
    logic [DIM_BITS-1:0]   out_col_reg;
    logic                  out_peak_reg;
    logic [COUNT_BITS-1:0] out_total_reg;
    logic                  out_end_reg;

    assign pending = head.mask & ~done_mask_reg;

    always_comb
    begin
        priority if (pending[SLOT_UP_LEFT])
        begin
            sel = SLOT_UP_LEFT;
        end
        else if (pending[SLOT_UP])
        begin
            sel = SLOT_UP;
        end
        else if (pending[SLOT_LEFT])
        begin
            sel = SLOT_LEFT;
        end
        else
        begin
            sel = SLOT_HERE;
        end
    end

    assign last  = ((pending & (pending - 1'b1)) == '0);
    assign load  = !empty && (!out_valid_reg || results.ready);
    assign pop   = load && last;
    assign peak  = head.peak[sel];
    assign total = count_reg + COUNT_BITS'(peak);

    always_comb
    begin
        done_mask_next = done_mask_reg;
        count_next     = count_reg;
        if (restart)
        begin
            done_mask_next = '0;
            count_next     = '0;
        end
        else if (load)
        begin
            done_mask_next = last ? 4'b0000 : (done_mask_reg | (4'b0001 << sel));
            count_next     = (last && head.frame_end) ? '0 : total;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_mask_reg <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            done_mask_reg <= done_mask_next;
            count_reg     <= count_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // The stored position is that of the newest pixel; the upper slots sit one row above it
    // and the left slots one column to its left, which the count from one cancels.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_row_reg   <= DIM_BITS'(head.row) + DIM_BITS'(sel[1]);
            out_col_reg   <= DIM_BITS'(head.col) + DIM_BITS'(sel[0]);
            out_peak_reg  <= peak;
            out_total_reg <= total;
            out_end_reg   <= last;
        end
    end

    assign results.valid      = out_valid_reg;
    assign results.pixel_row  = out_row_reg;
    assign results.pixel_col  = out_col_reg;
    assign results.is_peak    = out_peak_reg;
    assign results.peak_total = out_total_reg;
    assign results.run_end    = out_end_reg;

    a_head_has_work: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (head.mask != '0))
        else $error("queued request without results");

    a_done_subset: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> ((done_mask_reg & ~head.mask) == '0))
        else $error("delivered slot not in the request");

    a_frame_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (load && last && head.frame_end && !restart) |=> (count_reg == '0))
        else $error("peak count not cleared at frame end");

endmodule
